FILE: hw/rtl/xcd_pkg.sv
// Shared types, codes and constants for the XOR-checksum packet deframer.
package xcd_pkg;

	localparam int NUM_OPCODES_DEF = 8;
	localparam int TABLE_W         = 64;
	localparam int SLOT_W          = 3;

	// configuration register indexes
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_ENABLE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_OPCODE = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_LENGTH = 2'd2;

	// result status codes
	localparam logic [2:0] ST_MID     = 3'd0;
	localparam logic [2:0] ST_GOOD    = 3'd1;
	localparam logic [2:0] ST_BAD     = 3'd2;
	localparam logic [2:0] ST_UNKNOWN = 3'd3;
	localparam logic [2:0] ST_IGNORED = 3'd4;
	localparam logic [2:0] ST_TIMEOUT = 3'd5;

	localparam logic [7:0] MIN_LEN = 8'd2;

	typedef struct packed {
		logic               enable;
		logic [TABLE_W-1:0] opcode_table;
		logic [TABLE_W-1:0] length_table;
		logic               clear;      // asserted during a write to the enable register
	} cfg_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic [7:0]        len;
	} match_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data_byte;
	} item_t;

endpackage

FILE: hw/rtl/xcd_in_if.sv
// Input word channel: received byte or timeout tick.
interface xcd_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] data_byte;

	modport source (output valid, output cmd, output data_byte, input ready);
	modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

FILE: hw/rtl/xcd_out_if.sv
// Result word channel: echoed byte with position, slot and status.
interface xcd_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] echo_byte;
	logic [7:0] byte_position;
	logic [2:0] opcode_slot;

	modport source (output valid, output status, output echo_byte, output byte_position,
		output opcode_slot, input ready);
	modport sink   (input valid, input status, input echo_byte, input byte_position,
		input opcode_slot, output ready);
endinterface

FILE: hw/rtl/xcd_cfg.sv
// Configuration registers with the decoder clear pulse.
module xcd_cfg
	import xcd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [TABLE_W-1:0]   wr_data,
	output cfg_t                 cfg
);

	logic               enable_q;
	logic [TABLE_W-1:0] opcode_q;
	logic [TABLE_W-1:0] length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			opcode_q <= '0;
			length_q <= '0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_ENABLE: enable_q <= wr_data[0];
					REG_OPCODE: opcode_q <= wr_data;
					REG_LENGTH: length_q <= wr_data;
					default: ;
				endcase
			end
		end
	end

	assign cfg.enable       = enable_q;
	assign cfg.opcode_table = opcode_q;
	assign cfg.length_table = length_q;
	// frame state clears at the same edge as the enable write
	assign cfg.clear        = wr_en && (wr_index == REG_ENABLE);

endmodule

FILE: hw/rtl/xcd_match.sv
// Parallel opcode compare with lowest-slot priority and length floor.
module xcd_match
	import xcd_pkg::*;
#(
	parameter int NUM_OPCODES = NUM_OPCODES_DEF
) (
	input  logic [7:0]         data_byte,
	input  logic [TABLE_W-1:0] opcode_table,
	input  logic [TABLE_W-1:0] length_table,
	output match_t             result
);

	logic [7:0] raw_len;

	always_comb begin
		result  = '0;
		raw_len = '0;
		// walk downwards so the lowest matching slot is the one left standing
		for (int k = NUM_OPCODES - 1; k >= 0; k--) begin
			if (opcode_table[8*k +: 8] == data_byte) begin
				result.hit  = 1'b1;
				result.slot = SLOT_W'(k);
				raw_len     = length_table[8*k +: 8];
			end
		end
		result.len = (raw_len < MIN_LEN) ? MIN_LEN : raw_len;
	end

endmodule

FILE: hw/rtl/xcd_core.sv
// Frame tracking state, status decision and result register.
module xcd_core
	import xcd_pkg::*;
#(
	parameter int NUM_OPCODES = NUM_OPCODES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     item_valid,
	input  item_t    item,
	output logic     advance,
	xcd_out_if.source results
);

	logic              in_body_q;
	logic [7:0]        xor_q;
	logic [7:0]        seen_q;
	logic [7:0]        len_q;
	logic [SLOT_W-1:0] slot_q;

	logic              out_valid_q;
	logic [2:0]        status_q;
	logic [7:0]        echo_q;
	logic [7:0]        pos_q;
	logic [SLOT_W-1:0] oslot_q;

	match_t            m;

	logic              n_in_body;
	logic [7:0]        n_xor;
	logic [7:0]        n_seen;
	logic [7:0]        n_len;
	logic [SLOT_W-1:0] n_slot;
	logic [2:0]        r_status;
	logic [7:0]        r_echo;
	logic [7:0]        r_pos;
	logic [SLOT_W-1:0] r_slot;
	logic              last_byte;

	xcd_match #(.NUM_OPCODES(NUM_OPCODES)) u_match (
		.data_byte    (item.data_byte),
		.opcode_table (cfg.opcode_table),
		.length_table (cfg.length_table),
		.result       (m)
	);

	assign advance   = item_valid && (!out_valid_q || results.ready);
	assign last_byte = ({1'b0, seen_q} + 9'd1) >= {1'b0, len_q};

	always_comb begin
		n_in_body = in_body_q;
		n_xor     = xor_q;
		n_seen    = seen_q;
		n_len     = len_q;
		n_slot    = slot_q;
		r_status  = ST_MID;
		r_echo    = item.data_byte;
		r_pos     = '0;
		r_slot    = '0;
		if (!cfg.enable || item.cmd) begin
			n_in_body = 1'b0;
			n_xor     = '0;
			n_seen    = '0;
			n_len     = '0;
			n_slot    = '0;
			r_status  = cfg.enable ? ST_TIMEOUT : ST_IGNORED;
			r_echo    = cfg.enable ? 8'd0 : item.data_byte;
		end else if (!in_body_q) begin
			if (m.hit) begin
				n_in_body = 1'b1;
				n_xor     = item.data_byte;
				n_seen    = 8'd1;
				n_len     = m.len;
				n_slot    = m.slot;
				r_slot    = m.slot;
			end else begin
				r_status = ST_UNKNOWN;
			end
		end else begin
			r_pos  = seen_q;
			r_slot = slot_q;
			if (last_byte) begin
				r_status  = (xor_q == item.data_byte) ? ST_GOOD : ST_BAD;
				n_in_body = 1'b0;
				n_xor     = '0;
				n_seen    = '0;
				n_len     = '0;
				n_slot    = '0;
			end else begin
				n_xor  = xor_q ^ item.data_byte;
				n_seen = seen_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_body_q <= 1'b0;
			xor_q     <= '0;
			seen_q    <= '0;
			len_q     <= '0;
			slot_q    <= '0;
		end else if (cfg.clear) begin
			in_body_q <= 1'b0;
			xor_q     <= '0;
			seen_q    <= '0;
			len_q     <= '0;
			slot_q    <= '0;
		end else if (advance) begin
			in_body_q <= n_in_body;
			xor_q     <= n_xor;
			seen_q    <= n_seen;
			len_q     <= n_len;
			slot_q    <= n_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= r_status;
			echo_q   <= r_echo;
			pos_q    <= r_pos;
			oslot_q  <= r_slot;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.status        = status_q;
	assign results.echo_byte     = echo_q;
	assign results.byte_position = pos_q;
	assign results.opcode_slot   = oslot_q;

endmodule

FILE: hw/rtl/xor_checksum_packet_deframer.sv
// Top level of the XOR-checksum packet deframer: input register, config and core.
//
//   channel   dir   handshake      words
//   bytes     in    valid/ready    cmd, data_byte
//   results   out   valid/ready    status, echo_byte, byte_position, opcode_slot
//   wr_*      in    wr_en only     wr_index, wr_data (64 bit)
//
// One word per cycle sustained while the result channel is not stalled; a word
// is held in the input register at acceptance, then the decision and frame
// state update load the result register when the core advances.
// arst_n clears the frame state, the valid flags and the config to its defaults.
// A stalled result holds both stages; the input stage frees as soon as it moves on.
module xor_checksum_packet_deframer
	import xcd_pkg::*;
#(
	parameter int NUM_OPCODES = NUM_OPCODES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [TABLE_W-1:0]   wr_data,
	xcd_in_if.sink               bytes,
	xcd_out_if.source            results
);

	cfg_t  cfg;
	logic  valid_s1;
	item_t item_s1;
	logic  advance;

	xcd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	assign bytes.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			item_s1.cmd       <= bytes.cmd;
			item_s1.data_byte <= bytes.data_byte;
		end
	end

	xcd_core #(.NUM_OPCODES(NUM_OPCODES)) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (valid_s1),
		.item       (item_s1),
		.advance    (advance),
		.results    (results)
	);

endmodule
